>>> rtl/bgr_pkg.sv
// Shared types, constants and helpers for the bitmap glyph rasterizer.
package bgr_pkg;

    // Font geometry and store sizes.
    localparam int CHAR_COUNT  = 256;
    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int CHAR_W      = 8;
    localparam int ROW_W       = 4;
    localparam int GLYPH_DEPTH = CHAR_COUNT * MAX_ROWS;
    localparam int GLYPH_W     = 16;
    localparam int ADV_W       = 8;

    // Coordinates are 13-bit signed; arithmetic on them is done at 15 bits.
    localparam int COORD_W = 13;
    localparam int WIDE_W  = 15;
    localparam logic signed [WIDE_W-1:0] COORD_MAX = 15'sd4095;
    localparam logic signed [WIDE_W-1:0] COORD_MIN = -15'sd4096;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // Input item kinds, carried in tuser.
    typedef enum logic [1:0] {
        KIND_LOAD_WIDTH = 2'd0,
        KIND_LOAD_ROW   = 2'd1,
        KIND_SET_PEN    = 2'd2,
        KIND_DRAW       = 2'd3
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_FONT_HEIGHT    = 3'd0,
        REG_MAX_GLYPH_W    = 3'd1,
        REG_CLIP_LEFT      = 3'd2,
        REG_CLIP_TOP       = 3'd3,
        REG_CLIP_WIDTH     = 3'd4,
        REG_CLIP_HEIGHT    = 3'd5,
        REG_SURFACE_WIDTH  = 3'd6,
        REG_SURFACE_HEIGHT = 3'd7
    } t_reg_idx;

    // Per-row control handed from the row sequencer to the output stage.
    typedef struct packed {
        logic                      ok;
        logic                      last;
        logic signed [COORD_W-1:0] y;
    } t_row_ctl;

    // Clamp a widened coordinate to the 13-bit signed range.
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] c;
        c = v;
        if (v > COORD_MAX) c = COORD_MAX;
        if (v < COORD_MIN) c = COORD_MIN;
        return c[COORD_W-1:0];
    endfunction

endpackage

>>> rtl/bgr_ram.sv
// Generic simple dual-port RAM with a registered read port.
module bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and read port; the read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bgr_out.sv
// Output stage: masks a glyph row and holds the result beat for the consumer.
module bgr_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pend,
    input  bgr_pkg::t_row_ctl                  i_ctl,
    input  logic [bgr_pkg::GLYPH_W-1:0]        i_bits,
    input  logic [bgr_pkg::MAX_COLS-1:0]       i_colmask,
    input  logic signed [bgr_pkg::COORD_W-1:0] i_span_x,
    input  logic [7:0]                         i_color,
    input  logic                               i_ready,
    output logic                               o_load,
    output logic                               o_valid,
    output logic [bgr_pkg::M_TDATA_W-1:0]      o_data,
    output logic                               o_last
);
    import bgr_pkg::*;

    logic                  r_valid;
    logic [M_TDATA_W-1:0]  r_data;
    logic                  r_last;
    logic [GLYPH_W-1:0]    mask;

    // A pending row moves in whenever the register is empty or being drained.
    assign o_load = i_pend && (!r_valid || i_ready);
    assign mask   = i_ctl.ok ? (i_bits & i_colmask) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: row_y, span_x, pixel_mask, pixel_color from the lowest bit up.
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_data <= {6'd0, i_color, mask, i_span_x, i_ctl.y};
            r_last <= i_ctl.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

>>> rtl/bitmap_glyph_rasterizer_core.sv
// Top level of the bitmap glyph rasterizer: decode, width lookup and row sequencer.
// Loads, set pen and newline finish in the idle state; a character without width returns to idle after its width read.
// A drawn character goes through a width read, one glyph row read per cycle while the output
// stage keeps taking rows, and hand-off of the last row to the output stage.
// Synchronous active-low reset restores configuration, pen, state and width valid bits, not glyph memory.
module bitmap_glyph_rasterizer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // char_code[7:0], row_index[11:8], load_data[27:12], pen_x[40:28],
    // pen_y[53:41], ink_color[61:54], zero[63:62]
    input  logic [bgr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                         s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // row_y[12:0], span_x[25:13], pixel_mask[41:26], pixel_color[49:42], zero[55:50]
    output logic [bgr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [2:0]                         i_cfg_index,
    input  logic [12:0]                        i_cfg_data
);
    import bgr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WIDTH,
        S_ROWS
    } t_state;

    // Configuration registers.
    logic [4:0]                r_font_height;
    logic [4:0]                r_max_w;
    logic signed [COORD_W-1:0] r_clip_left;
    logic signed [COORD_W-1:0] r_clip_top;
    logic [COORD_W-1:0]        r_clip_w;
    logic [COORD_W-1:0]        r_clip_h;
    logic [COORD_W-1:0]        r_surf_w;
    logic [COORD_W-1:0]        r_surf_h;

    // Pen and draw state.
    logic signed [COORD_W-1:0] r_pen_x;
    logic signed [COORD_W-1:0] r_pen_y;
    logic signed [COORD_W-1:0] r_origin_x;
    logic [7:0]                r_color;
    logic [CHAR_COUNT-1:0]     r_wvalid;
    t_state                    r_state;
    logic [CHAR_W-1:0]         r_code;
    logic signed [COORD_W-1:0] r_span_x;
    logic [MAX_COLS-1:0]       r_colmask;
    logic [4:0]                r_rows;
    logic [4:0]                r_row;
    logic                      r_pend;
    t_row_ctl                  r_pend_ctl;

    // Unpacked input beat.
    t_kind                     in_kind;
    logic [CHAR_W-1:0]         in_code;
    logic [ROW_W-1:0]          in_row;
    logic [GLYPH_W-1:0]        in_load;
    logic signed [COORD_W-1:0] in_pen_x;
    logic signed [COORD_W-1:0] in_pen_y;
    logic [7:0]                in_ink;
    logic                      in_acc;

    // Memory ports.
    logic [ADV_W-1:0]          adv_q;
    logic [GLYPH_W-1:0]        glyph_q;
    logic                      row_issue;
    logic                      out_load;

    // Width stage and row stage arithmetic.
    logic [ADV_W-1:0]          gw;
    logic [5:0]                byte_cols;
    logic [5:0]                col_lim;
    logic [ADV_W-1:0]          cols_w;
    logic [4:0]                cols;
    logic [4:0]                rows_n;
    logic signed [WIDE_W-1:0]  cx0, cx1, cy0, cy1, sw, sh;
    logic [MAX_COLS-1:0]       colmask;
    logic signed [WIDE_W-1:0]  pen_adv;
    logic signed [WIDE_W-1:0]  pen_nl;
    logic signed [WIDE_W-1:0]  dy;
    t_row_ctl                  row_ctl;

    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_code  = s_axis_tdata[7:0];
    assign in_row   = s_axis_tdata[11:8];
    assign in_load  = s_axis_tdata[27:12];
    assign in_pen_x = s_axis_tdata[40:28];
    assign in_pen_y = s_axis_tdata[53:41];
    assign in_ink   = s_axis_tdata[61:54];

    // One item at a time; the output register still decouples the consumer.
    assign s_axis_tready = (r_state == S_IDLE) && !r_pend;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Advance width table.
    bgr_ram #(
        .WIDTH(ADV_W),
        .DEPTH(CHAR_COUNT)
    ) u_adv_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && in_kind == KIND_LOAD_WIDTH),
        .i_waddr(in_code),
        .i_wdata(in_load[ADV_W-1:0]),
        .i_re   (in_acc && in_kind == KIND_DRAW),
        .i_raddr(in_code),
        .o_rdata(adv_q)
    );

    // Glyph row store, addressed by character and row.
    bgr_ram #(
        .WIDTH(GLYPH_W),
        .DEPTH(GLYPH_DEPTH)
    ) u_glyph_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc && in_kind == KIND_LOAD_ROW),
        .i_waddr({in_code, in_row}),
        .i_wdata(in_load),
        .i_re   (row_issue),
        .i_raddr({r_code, r_row[ROW_W-1:0]}),
        .o_rdata(glyph_q)
    );

    // Clip bounds, widened so that the far edges cannot wrap.
    assign cx0 = WIDE_W'(r_clip_left);
    assign cy0 = WIDE_W'(r_clip_top);
    assign cx1 = cx0 + $signed({2'b00, r_clip_w});
    assign cy1 = cy0 + $signed({2'b00, r_clip_h});
    assign sw  = $signed({2'b00, r_surf_w});
    assign sh  = $signed({2'b00, r_surf_h});

    // Width stage: drawable columns, row count and per-column clip mask.
    assign gw        = r_wvalid[r_code] ? adv_q : '0;
    assign byte_cols = ({1'b0, r_max_w} + 6'd7) & 6'b111000;
    assign col_lim   = (byte_cols > 6'(MAX_COLS)) ? 6'(MAX_COLS) : byte_cols;
    assign cols_w    = (gw < {2'b00, col_lim}) ? gw : {2'b00, col_lim};
    assign cols      = cols_w[4:0];
    assign rows_n    = (r_font_height > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : r_font_height;
    assign pen_adv   = WIDE_W'(r_pen_x) + $signed({7'd0, gw});
    assign pen_nl    = WIDE_W'(r_pen_y) + $signed({10'd0, r_font_height});

    always_comb begin
        logic signed [WIDE_W-1:0] dx;
        for (int c = 0; c < MAX_COLS; c++) begin
            dx = WIDE_W'(r_pen_x) + $signed(WIDE_W'(c));
            colmask[c] = (5'(c) < cols) && (dx >= cx0) && (dx < cx1) &&
                         (dx >= 0) && (dx < sw);
        end
    end

    // Row stage: surface row and its vertical clip test.
    assign dy          = WIDE_W'(r_pen_y) + $signed({10'd0, r_row});
    assign row_ctl.ok  = (dy >= cy0) && (dy < cy1) && (dy >= 0) && (dy < sh);
    assign row_ctl.last = (r_row + 5'd1 == r_rows);
    assign row_ctl.y   = sat_coord(dy);

    // A row read is issued only when the previous one has left the read register.
    assign row_issue = (r_state == S_ROWS) && (!r_pend || out_load);

    bgr_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pend   (r_pend),
        .i_ctl    (r_pend_ctl),
        .i_bits   (glyph_q),
        .i_colmask(r_colmask),
        .i_span_x (r_span_x),
        .i_color  (r_color),
        .i_ready  (m_axis_tready),
        .o_load   (out_load),
        .o_valid  (m_axis_tvalid),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

    // Configuration, pen state and the draw sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_height <= 5'd16;
            r_max_w       <= 5'd16;
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_w      <= 13'd4096;
            r_clip_h      <= 13'd4096;
            r_surf_w      <= 13'd4096;
            r_surf_h      <= 13'd4096;
            r_pen_x       <= '0;
            r_pen_y       <= '0;
            r_origin_x    <= '0;
            r_color       <= '0;
            r_wvalid      <= '0;
            r_state       <= S_IDLE;
            r_pend        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_FONT_HEIGHT:    r_font_height <= i_cfg_data[4:0];
                    REG_MAX_GLYPH_W:    r_max_w       <= i_cfg_data[4:0];
                    REG_CLIP_LEFT:      r_clip_left   <= i_cfg_data;
                    REG_CLIP_TOP:       r_clip_top    <= i_cfg_data;
                    REG_CLIP_WIDTH:     r_clip_w      <= i_cfg_data;
                    REG_CLIP_HEIGHT:    r_clip_h      <= i_cfg_data;
                    REG_SURFACE_WIDTH:  r_surf_w      <= i_cfg_data;
                    REG_SURFACE_HEIGHT: r_surf_h      <= i_cfg_data;
                    default: ;
                endcase
            end

            if (row_issue) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (in_kind)
                            KIND_LOAD_WIDTH: r_wvalid[in_code] <= 1'b1;
                            KIND_SET_PEN: begin
                                r_pen_x    <= in_pen_x;
                                r_origin_x <= in_pen_x;
                                r_pen_y    <= in_pen_y;
                                r_color    <= in_ink;
                            end
                            KIND_DRAW: begin
                                if (in_code == NEWLINE_CODE) begin
                                    r_pen_x <= r_origin_x;
                                    r_pen_y <= sat_coord(pen_nl);
                                end else begin
                                    r_code  <= in_code;
                                    r_state <= S_WIDTH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WIDTH: begin
                    if (gw == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_span_x  <= r_pen_x;
                        r_pen_x   <= sat_coord(pen_adv);
                        r_colmask <= colmask;
                        r_rows    <= rows_n;
                        r_row     <= '0;
                        r_state   <= (rows_n == '0) ? S_IDLE : S_ROWS;
                    end
                end
                S_ROWS: begin
                    if (row_issue) begin
                        r_pend_ctl <= row_ctl;
                        r_row      <= r_row + 5'd1;
                        if (row_ctl.last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // A draw beat other than newline always goes on to the width lookup.
    a_draw_to_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_kind == KIND_DRAW && in_code != NEWLINE_CODE)
        |=> (r_state == S_WIDTH))
        else $error("draw beat did not start a width lookup");

    // A new row read must never overwrite a row that the output stage has not taken.
    a_no_row_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (row_issue && r_pend) |-> out_load)
        else $error("glyph row read overran a pending row");

    // The pen does not move while rows of a character are being emitted.
    a_pen_stable_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROWS) |=> $stable(r_pen_x) && $stable(r_pen_y))
        else $error("pen changed during row emission");

    // Input is never taken, and no width lookup runs, while a glyph row is still pending.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !(s_axis_tvalid && s_axis_tready) && (r_state != S_WIDTH))
        else $error("new item started with a row pending");
`endif

endmodule
